/* hw/rtl/lcdrs_pkg.sv */
// Shared constants and types of the character LCD refresh scanner.
// Depends on nothing; the top level, the scan sequencer and the checker refer to it by scoped names.
package lcdrs_pkg;

  localparam int COLUMNS = 16;
  localparam int ROWS    = 2;
  localparam int CELLS   = COLUMNS * ROWS;
  localparam int CELL_AW = (CELLS > 1) ? $clog2(CELLS) : 1;

  localparam int COL_W  = 6;
  localparam int ROW_W  = 1;
  localparam int BYTE_W = 8;

  localparam logic [BYTE_W-1:0] BLANK_CODE  = 8'h20;
  localparam logic [BYTE_W-1:0] ROW_STRIDE  = 8'h40;
  localparam logic [BYTE_W-1:0] SET_ADDRESS = 8'h80;

  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam logic RS_COMMAND = 1'b0;
  localparam logic RS_DATA    = 1'b1;

  // What the scan sequencer asks of the datapath for one refresh tick
  typedef struct packed {
    logic                      cmd;
    logic [CELL_AW-1:0]        addr;
    logic [BYTE_W-1:0]         cmd_byte;
  } scan_req_t;

endpackage

/* hw/rtl/char_lcd_refresh_scanner_top.sv */
// Top level of the character LCD refresh scanner: frame buffer RAM, valid bits, output stages.
// Depends on lcdrs_pkg, lcdrs_ram and lcdrs_scan.
//
// While in_ready is high the block takes one transaction per cycle on the input channel,
// writes and ticks alike. A write stores a character into the frame buffer and gives no
// result; a tick gives one byte: the buffered character (register_select high) or, once the
// scan runs past the last column, a set-address command for column 0 of the next row
// (register_select low). A tick result passes through the single, registered read port of
// the frame buffer RAM and then the output register. The read stage and the output register
// form a two-deep queue, so input is still taken while one result waits at the output.
// Reset makes the buffer read as spaces at once through a valid bit per cell; there is no
// clearing pass.
module char_lcd_refresh_scanner_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_operation,
  input  logic [lcdrs_pkg::COL_W-1:0]  in_column,
  input  logic [lcdrs_pkg::ROW_W-1:0]  in_row,
  input  logic [lcdrs_pkg::BYTE_W-1:0] in_character,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [lcdrs_pkg::BYTE_W-1:0] out_lcd_byte,
  output logic                         out_register_select
);

  lcdrs_pkg::scan_req_t req;

  logic in_acc, tick_acc, wr_acc, wr_in_range;
  logic s1_move;
  logic [lcdrs_pkg::CELL_AW-1:0] waddr;
  logic [lcdrs_pkg::BYTE_W-1:0]  rdata;

  logic [lcdrs_pkg::CELLS-1:0] vld_r, vld_nxt;

  logic                         s1_valid_r, s1_valid_nxt;
  logic                         s1_cmd_r;
  logic                         s1_vld_r;
  logic [lcdrs_pkg::BYTE_W-1:0] s1_cmd_byte_r;
  logic [lcdrs_pkg::BYTE_W-1:0] s1_byte;

  logic                         out_valid_r, out_valid_nxt;
  logic [lcdrs_pkg::BYTE_W-1:0] out_byte_r;
  logic                         out_rs_r;

  assign s1_move  = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || s1_move;
  assign in_acc   = in_valid && in_ready;
  assign tick_acc = in_acc && (in_operation == lcdrs_pkg::OP_TICK);

  assign wr_in_range = (int'(in_column) < lcdrs_pkg::COLUMNS)
                    && (int'(in_row) < lcdrs_pkg::ROWS);
  assign wr_acc = in_acc && (in_operation == lcdrs_pkg::OP_WRITE) && wr_in_range;
  assign waddr  = lcdrs_pkg::CELL_AW'(int'(in_row) * lcdrs_pkg::COLUMNS + int'(in_column));

  lcdrs_scan u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (tick_acc),
    .req     (req)
  );

  // Writes land at acceptance, so a later tick's read always sees them
  lcdrs_ram #(
    .WIDTH (lcdrs_pkg::BYTE_W),
    .DEPTH (lcdrs_pkg::CELLS)
  ) u_fb_ram (
    .clk   (clk),
    .we    (wr_acc),
    .waddr (waddr),
    .wdata (in_character),
    .re    (tick_acc),
    .raddr (req.addr),
    .rdata (rdata)
  );

  always_comb begin
    vld_nxt = vld_r;
    if (wr_acc) begin
      vld_nxt[waddr] = 1'b1;
    end
  end

  always_comb begin
    if (tick_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_move) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
    out_valid_nxt = s1_move ? s1_valid_r : out_valid_r;
  end

  // A cell never written reads as a space
  always_comb begin
    if (s1_cmd_r) begin
      s1_byte = s1_cmd_byte_r;
    end else if (s1_vld_r) begin
      s1_byte = rdata;
    end else begin
      s1_byte = lcdrs_pkg::BLANK_CODE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      vld_r       <= vld_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_acc) begin
      s1_cmd_r      <= req.cmd;
      s1_cmd_byte_r <= req.cmd_byte;
      s1_vld_r      <= vld_r[req.addr];
    end
    if (s1_move && s1_valid_r) begin
      out_byte_r <= s1_byte;
      out_rs_r   <= s1_cmd_r ? lcdrs_pkg::RS_COMMAND : lcdrs_pkg::RS_DATA;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_lcd_byte        = out_byte_r;
  assign out_register_select = out_rs_r;

endmodule

/* hw/rtl/lcdrs_ram.sv */
// Generic single-write, single-read RAM with a registered, enabled read port.
// No dependencies.
module lcdrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/lcdrs_scan.sv */
// Scan position sequencer: column and row counters, cell address and set-address command.
// Depends on lcdrs_pkg.
module lcdrs_scan (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  advance,
  output lcdrs_pkg::scan_req_t  req
);

  logic [lcdrs_pkg::COL_W-1:0] scan_col_r, scan_col_nxt;
  logic [lcdrs_pkg::ROW_W-1:0] scan_row_r, scan_row_nxt;
  logic [lcdrs_pkg::ROW_W-1:0] next_row;
  logic                        past_end;

  assign past_end = int'(scan_col_r) >= lcdrs_pkg::COLUMNS;

  always_comb begin
    // wrap to the first row after the last one
    if (int'(scan_row_r) + 1 >= lcdrs_pkg::ROWS) begin
      next_row = '0;
    end else begin
      next_row = scan_row_r + lcdrs_pkg::ROW_W'(1);
    end
  end

  always_comb begin
    req.cmd      = past_end;
    req.addr     = lcdrs_pkg::CELL_AW'(int'(scan_row_r) * lcdrs_pkg::COLUMNS
                                       + int'(scan_col_r));
    req.cmd_byte = lcdrs_pkg::SET_ADDRESS
                 | lcdrs_pkg::BYTE_W'(int'(next_row) * int'(lcdrs_pkg::ROW_STRIDE));
    scan_col_nxt = scan_col_r;
    scan_row_nxt = scan_row_r;
    if (advance) begin
      if (past_end) begin
        scan_col_nxt = '0;
        scan_row_nxt = next_row;
      end else begin
        scan_col_nxt = scan_col_r + lcdrs_pkg::COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_col_r <= '0;
      scan_row_r <= '0;
    end else begin
      scan_col_r <= scan_col_nxt;
      scan_row_r <= scan_row_nxt;
    end
  end

endmodule

/* hw/rtl/lcdrs_checker.sv */
// Port-level checks of the character LCD refresh scanner, bound to its top level.
// Depends on lcdrs_pkg and char_lcd_refresh_scanner_top.
module lcdrs_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [lcdrs_pkg::BYTE_W-1:0] out_lcd_byte,
  input logic                         out_register_select
);

  // Reset empties the output side
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result offered right after reset");

  // Take input whenever the output register is empty
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input refused while output side empty");

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_lcd_byte)
                                && $stable(out_register_select))
    else $error("stalled result changed");

  // A command always addresses column 0 of some row
  a_cmd_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_register_select == lcdrs_pkg::RS_COMMAND)
    |-> (out_lcd_byte[7] == 1'b1) && (out_lcd_byte[5:0] == 6'd0))
    else $error("malformed set-address command");

  // Two commands never follow one another
  a_cmd_then_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && (out_register_select == lcdrs_pkg::RS_COMMAND)
    |=> !out_valid || (out_register_select == lcdrs_pkg::RS_DATA))
    else $error("command followed by command");

endmodule

bind char_lcd_refresh_scanner_top lcdrs_checker u_lcdrs_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_ready            (in_ready),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_lcd_byte        (out_lcd_byte),
  .out_register_select (out_register_select)
);
